// ----- hw/rtl/cos_pkg.sv -----
// Shared types and constants for the cosine similarity block.
// Used by cos_ctrl, cos_dp and the cosine_similarity top level.
package cos_pkg;

  localparam int MAX_ELEMENTS_DEF = 16384;
  localparam int SAMPLE_BITS_DEF  = 16;

  localparam int NORM_W  = 62;
  localparam int ROOT_W  = 31;
  localparam int PROD_W  = 2 * ROOT_W;
  localparam int REM_W   = 64;
  localparam int Q_W     = 17;
  localparam int CNT_W   = 7;
  localparam int K_W     = 5;
  localparam int PRE_W   = 2;

  localparam int DIV_BASE_STEPS = 15;
  localparam int PRE_STEPS      = 3;

  localparam logic [Q_W-1:0] Q_SAT   = 17'h10000;
  localparam logic [Q_W-1:0] Q_POS   = 17'd32767;
  localparam logic [Q_W-1:0] Q_NEG   = 17'd32768;
  localparam logic [15:0]    SIM_MAX = 16'h7fff;
  localparam logic [15:0]    SIM_MIN = 16'h8000;

  typedef enum logic [3:0] {
    ST_ACC,
    ST_DRAIN,
    ST_TEST,
    ST_NORM,
    ST_SQRT,
    ST_MUL,
    ST_DIV_INIT,
    ST_DIV_PRE,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic test;
    logic norm_load;
    logic norm_second;
    logic norm_shift;
    logic sqrt_init;
    logic sqrt_step;
    logic sel;
    logic mul;
    logic div_init;
    logic div_pre;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic energy_zero;
    logic norm_done;
    logic sqrt_last;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

// ----- hw/rtl/cosine_similarity.sv -----
// Cosine similarity of two streamed vectors, one element pair per cycle, Q1.15 result.
// Accumulation takes one pair per cycle. After the last pair the block stalls its input
// while the shared one-bit-per-cycle square root and the one-bit-per-cycle divider run,
// for longer as the normalizing shifts ka, kb (0..30) grow; a zero-energy vector skips
// the root and the divider. Synchronous active-low reset clears the sums and the control
// state; the block then accepts pairs at once.
module cosine_similarity #(
  parameter int MAX_ELEMENTS = cos_pkg::MAX_ELEMENTS_DEF,
  parameter int SAMPLE_BITS  = cos_pkg::SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_a_value,
  input  logic [15:0] in_b_value,
  input  logic        in_last_element,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_similarity,
  output logic        out_degenerate
);

  cos_pkg::cmd_t    cmd;
  cos_pkg::status_t status;
  logic             in_take;

  assign in_take = in_valid && !in_stall;

  cos_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_take  (in_take),
    .in_last  (in_last_element),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  cos_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_take        (in_take),
    .in_a_value     (in_a_value),
    .in_b_value     (in_b_value),
    .cmd            (cmd),
    .status         (status),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_similarity (out_similarity),
    .out_degenerate (out_degenerate)
  );

endmodule

// ----- hw/rtl/cos_ctrl.sv -----
// Sequencer for the cosine similarity block: accumulate, then root, multiply, divide (skipped for zero energy).
// Depends on cos_pkg; drives cos_dp through cos_pkg::cmd_t.
module cos_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_take,
  input  logic              in_last,
  input  cos_pkg::status_t  status,
  output cos_pkg::cmd_t     cmd,
  output logic              in_stall
);

  cos_pkg::state_t            state_r, state_nxt;
  logic                       sel_r, sel_nxt;
  logic [cos_pkg::PRE_W-1:0]  pre_cnt_r, pre_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= cos_pkg::ST_ACC;
      sel_r     <= 1'b0;
      pre_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      sel_r     <= sel_nxt;
      pre_cnt_r <= pre_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    sel_nxt     = sel_r;
    pre_cnt_nxt = pre_cnt_r;
    case (state_r)
      cos_pkg::ST_ACC: begin
        if (in_take && in_last) state_nxt = cos_pkg::ST_DRAIN;
      end
      cos_pkg::ST_DRAIN: state_nxt = cos_pkg::ST_TEST;
      cos_pkg::ST_TEST: begin
        sel_nxt   = 1'b0;
        state_nxt = status.energy_zero ? cos_pkg::ST_EMIT : cos_pkg::ST_NORM;
      end
      cos_pkg::ST_NORM: begin
        if (status.norm_done) state_nxt = cos_pkg::ST_SQRT;
      end
      cos_pkg::ST_SQRT: begin
        if (status.sqrt_last) begin
          if (!sel_r) begin
            sel_nxt   = 1'b1;
            state_nxt = cos_pkg::ST_NORM;
          end else begin
            state_nxt = cos_pkg::ST_MUL;
          end
        end
      end
      cos_pkg::ST_MUL: state_nxt = cos_pkg::ST_DIV_INIT;
      cos_pkg::ST_DIV_INIT: begin
        pre_cnt_nxt = '0;
        state_nxt   = cos_pkg::ST_DIV_PRE;
      end
      cos_pkg::ST_DIV_PRE: begin
        pre_cnt_nxt = pre_cnt_r + 1'b1;
        if (pre_cnt_r == cos_pkg::PRE_W'(cos_pkg::PRE_STEPS - 1)) state_nxt = cos_pkg::ST_DIV;
      end
      cos_pkg::ST_DIV: begin
        if (status.div_last) state_nxt = cos_pkg::ST_EMIT;
      end
      cos_pkg::ST_EMIT: begin
        if (status.out_free) state_nxt = cos_pkg::ST_ACC;
      end
      default: state_nxt = cos_pkg::ST_ACC;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.sel  = sel_r;
    in_stall = 1'b1;
    case (state_r)
      cos_pkg::ST_ACC: in_stall = 1'b0;
      cos_pkg::ST_DRAIN: ;
      cos_pkg::ST_TEST: begin
        cmd.test      = 1'b1;
        cmd.norm_load = !status.energy_zero;
      end
      cos_pkg::ST_NORM: begin
        cmd.norm_shift = !status.norm_done;
        cmd.sqrt_init  = status.norm_done;
      end
      cos_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (status.sqrt_last && !sel_r) begin
          cmd.norm_load   = 1'b1;
          cmd.norm_second = 1'b1;
        end
      end
      cos_pkg::ST_MUL:      cmd.mul      = 1'b1;
      cos_pkg::ST_DIV_INIT: cmd.div_init = 1'b1;
      cos_pkg::ST_DIV_PRE:  cmd.div_pre  = 1'b1;
      cos_pkg::ST_DIV:      cmd.div_step = 1'b1;
      cos_pkg::ST_EMIT:     cmd.emit     = status.out_free;
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/cos_dp.sv -----
// Datapath: product stage, saturating sums, normalizer, shared square root,
// root multiplier, restoring divider and result register. Depends on cos_pkg.
module cos_dp #(
  parameter int MAX_ELEMENTS = cos_pkg::MAX_ELEMENTS_DEF,
  parameter int SAMPLE_BITS  = cos_pkg::SAMPLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_take,
  input  logic [15:0]        in_a_value,
  input  logic [15:0]        in_b_value,
  input  cos_pkg::cmd_t      cmd,
  output cos_pkg::status_t   status,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [15:0]        out_similarity,
  output logic               out_degenerate
);

  localparam int SW    = SAMPLE_BITS;
  localparam int GROW  = $clog2(MAX_ELEMENTS);
  localparam int EW    = (2 * SW + GROW > 62) ? 62 : 2 * SW + GROW;
  localparam int PW    = 2 * SW;
  localparam logic [cos_pkg::NORM_W-1:0] SQRT_BIT0 =
    cos_pkg::NORM_W'(1) << (cos_pkg::NORM_W - 2);

  logic signed [SW-1:0] a_s, b_s;

  generate
    if (SW <= 16) begin : g_narrow
      assign a_s = in_a_value[SW-1:0];
      assign b_s = in_b_value[SW-1:0];
    end else begin : g_wide
      assign a_s = {{(SW-16){in_a_value[15]}}, in_a_value};
      assign b_s = {{(SW-16){in_b_value[15]}}, in_b_value};
    end
  endgenerate

  // product stage
  logic signed [PW-1:0] m_dot, m_ea, m_eb;
  logic signed [PW-1:0] p_dot_r;
  logic [PW-1:0]        p_ea_r, p_eb_r;
  logic                 p_vld_r;

  assign m_dot = a_s * b_s;
  assign m_ea  = a_s * a_s;
  assign m_eb  = b_s * b_s;

  always_ff @(posedge clk) begin
    if (!rst_n) p_vld_r <= 1'b0;
    else        p_vld_r <= in_take;
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      p_dot_r <= m_dot;
      p_ea_r  <= m_ea;
      p_eb_r  <= m_eb;
    end
  end

  // saturating sums
  logic signed [EW:0]   dot_sum_r;
  logic [EW-1:0]        energy_first_r, energy_second_r;
  logic signed [EW+1:0] dsum;
  logic [EW:0]          esum_a, esum_b;
  logic signed [EW:0]   dot_sat;
  logic [EW-1:0]        ea_sat, eb_sat;

  assign dsum   = {dot_sum_r[EW], dot_sum_r} + {{(EW+2-PW){p_dot_r[PW-1]}}, p_dot_r};
  assign esum_a = {1'b0, energy_first_r}  + {{(EW+1-PW){1'b0}}, p_ea_r};
  assign esum_b = {1'b0, energy_second_r} + {{(EW+1-PW){1'b0}}, p_eb_r};

  always_comb begin
    if (dsum[EW+1] != dsum[EW]) dot_sat = {dsum[EW+1], {EW{~dsum[EW+1]}}};
    else                        dot_sat = dsum[EW:0];
    ea_sat = esum_a[EW] ? {EW{1'b1}} : esum_a[EW-1:0];
    eb_sat = esum_b[EW] ? {EW{1'b1}} : esum_b[EW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.emit) begin
      dot_sum_r       <= '0;
      energy_first_r  <= '0;
      energy_second_r <= '0;
    end else if (p_vld_r) begin
      dot_sum_r       <= dot_sat;
      energy_first_r  <= ea_sat;
      energy_second_r <= eb_sat;
    end
  end

  // normalizer: shift by two until a bit of the top pair is set
  logic [cos_pkg::NORM_W-1:0] norm_r;
  logic [cos_pkg::K_W-1:0]    k_r, ka_r, kb_r;

  always_ff @(posedge clk) begin
    if (cmd.norm_load) begin
      norm_r <= cmd.norm_second ? cos_pkg::NORM_W'(energy_second_r)
                                : cos_pkg::NORM_W'(energy_first_r);
      k_r    <= '0;
    end else if (cmd.norm_shift) begin
      norm_r <= norm_r << 2;
      k_r    <= k_r + 1'b1;
    end
  end

  // digit-by-digit square root, one result bit per cycle
  logic [cos_pkg::NORM_W-1:0] sq_v_r, sq_r_r, sq_bit_r;
  logic [cos_pkg::NORM_W:0]   sq_t;
  logic                       sq_ge;
  logic [cos_pkg::NORM_W-1:0] sq_r_nxt;
  logic [cos_pkg::ROOT_W-1:0] ra_r, rb_r;

  assign sq_t     = {1'b0, sq_r_r} + {1'b0, sq_bit_r};
  assign sq_ge    = {1'b0, sq_v_r} >= sq_t;
  assign sq_r_nxt = sq_ge ? (sq_r_r >> 1) + sq_bit_r : sq_r_r >> 1;

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sq_v_r   <= norm_r;
      sq_r_r   <= '0;
      sq_bit_r <= SQRT_BIT0;
    end else if (cmd.sqrt_step) begin
      if (sq_ge) sq_v_r <= sq_v_r - sq_t[cos_pkg::NORM_W-1:0];
      sq_r_r   <= sq_r_nxt;
      sq_bit_r <= sq_bit_r >> 2;
      if (sq_bit_r[0]) begin
        if (cmd.sel) begin
          rb_r <= sq_r_nxt[cos_pkg::ROOT_W-1:0];
          kb_r <= k_r;
        end else begin
          ra_r <= sq_r_nxt[cos_pkg::ROOT_W-1:0];
          ka_r <= k_r;
        end
      end
    end
  end

  // divisor
  logic [cos_pkg::PROD_W-1:0] d_prod, d_r;

  assign d_prod = ra_r * rb_r;

  always_ff @(posedge clk) begin
    if (cmd.mul) d_r <= d_prod;
  end

  // restoring divider with saturating quotient
  logic [EW:0]               dot_mag;
  logic [cos_pkg::REM_W-1:0] rem_r, dsh_r, div_src;
  logic [cos_pkg::Q_W-1:0]   q_r;
  logic [cos_pkg::Q_W:0]     q_shift;
  logic [cos_pkg::CNT_W-1:0] cnt_r;
  logic                      neg_r, deg_r, div_ge;

  assign dot_mag = dot_sum_r[EW] ? (~dot_sum_r + 1'b1) : dot_sum_r;
  assign div_src = cmd.div_step ? {rem_r[cos_pkg::REM_W-2:0], 1'b0} : rem_r;
  assign div_ge  = div_src >= dsh_r;
  assign q_shift = {q_r, div_ge};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= cos_pkg::REM_W'(dot_mag);
      dsh_r <= {d_r, 2'b00};
      q_r   <= '0;
      neg_r <= dot_sum_r[EW];
      cnt_r <= cos_pkg::CNT_W'(cos_pkg::DIV_BASE_STEPS) + cos_pkg::CNT_W'(ka_r)
               + cos_pkg::CNT_W'(kb_r);
    end else if (cmd.div_pre || cmd.div_step) begin
      rem_r <= div_ge ? div_src - dsh_r : div_src;
      q_r   <= (q_shift > {1'b0, cos_pkg::Q_SAT}) ? cos_pkg::Q_SAT
                                                   : q_shift[cos_pkg::Q_W-1:0];
      if (cmd.div_pre && dsh_r != {2'b00, d_r}) dsh_r <= dsh_r >> 1;
      if (cmd.div_step) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.test) deg_r <= status.energy_zero;
  end

  // result register
  logic        out_valid_r;
  logic [15:0] out_sim_r, sim_val;
  logic        out_deg_r;

  always_comb begin
    if (deg_r)               sim_val = '0;
    else if (neg_r)          sim_val = (q_r >= cos_pkg::Q_NEG) ? cos_pkg::SIM_MIN
                                                              : ~q_r[15:0] + 1'b1;
    else                     sim_val = (q_r >= cos_pkg::Q_POS) ? cos_pkg::SIM_MAX
                                                              : q_r[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n)                      out_valid_r <= 1'b0;
    else if (cmd.emit)               out_valid_r <= 1'b1;
    else if (!out_stall)             out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_sim_r <= sim_val;
      out_deg_r <= deg_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_similarity = out_sim_r;
  assign out_degenerate = out_deg_r;

  assign status.energy_zero = (energy_first_r == '0) || (energy_second_r == '0);
  assign status.norm_done   = |norm_r[cos_pkg::NORM_W-1:cos_pkg::NORM_W-2];
  assign status.sqrt_last   = sq_bit_r[0];
  assign status.div_last    = (cnt_r == cos_pkg::CNT_W'(1));
  assign status.out_free    = !out_valid_r || !out_stall;

endmodule

// ----- hw/rtl/cos_checker.sv -----
// Port-level checks for cosine_similarity, attached by bind.
// Depends only on the top-level ports.
module cos_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [15:0] in_a_value,
  input logic [15:0] in_b_value,
  input logic        in_last_element,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_similarity,
  input logic        out_degenerate
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_similarity) && $stable(out_degenerate))
    else $error("stalled result changed");

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_similarity == 16'h0000)
    else $error("degenerate result with nonzero similarity");

  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_element |=> in_stall)
    else $error("input taken right after last element");

  a_result_after_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result issued while input was open");

endmodule

bind cosine_similarity cos_checker u_cos_checker (.*);

// ----- sim/cosine_similarity_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for cosine_similarity: streams element pairs, predicts each
// Q1.15 similarity and degenerate flag, and checks every result transaction.
// Depends on cos_pkg and the cosine_similarity RTL only.
module cosine_similarity_tb;

  typedef longint unsigned u64_t;

  localparam int   GROW_W    = $clog2(cos_pkg::MAX_ELEMENTS_DEF);
  localparam int   RAW_W     = 2 * cos_pkg::SAMPLE_BITS_DEF + GROW_W;
  localparam int   SUM_W     = (RAW_W > 62) ? 62 : RAW_W;
  localparam u64_t ENERGY_HI = (u64_t'(1) << SUM_W) - 1;
  localparam longint DOT_HI  = longint'(ENERGY_HI);
  localparam longint DOT_LO  = -DOT_HI - 1;
  localparam int   LONG_LEN  = 32;
  localparam int   HOLD_AT   = 30;
  localparam int   HOLD_LEN  = 600;

  typedef struct {
    logic [15:0] a;
    logic [15:0] b;
    logic        last;
    int          gap;
    logic        drain;
  } pair_t;

  typedef struct {
    logic [15:0] sim;
    logic        deg;
  } cos_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_a_value = 16'h0000;
  logic [15:0] in_b_value = 16'h0000;
  logic        in_last_element = 1'b0;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_similarity;
  logic        out_degenerate;
  logic        short_stall = 1'b0;
  logic        long_stall = 1'b0;

  pair_t    pair_q[$];
  cos_res_t cosine_q[$];
  pair_t    nxt;
  cos_res_t got;
  int       wait_cnt = 0;
  int       hold_left = 0;
  int       long_left = 0;
  int       long_seen = 0;
  int       fail_count = 0;

  longint dot_acc = 0;
  u64_t   energy_a = 0;
  u64_t   energy_b = 0;

  assign out_stall = short_stall || long_stall;

  cosine_similarity DUT (.*);

  always #1 clk = ~clk;

  function automatic u64_t int_sqrt(input u64_t v);
    u64_t r;
    u64_t probe;
    r = 0;
    probe = u64_t'(1) << 62;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= r + probe) begin
        v -= r + probe;
        r = (r >> 1) + probe;
      end else begin
        r >>= 1;
      end
      probe >>= 2;
    end
    return r;
  endfunction

  // root of e * 4^k, normalized into [2^30, 2^31)
  function automatic u64_t norm_root(input u64_t e, output int k);
    k = 0;
    while (e < (u64_t'(1) << 60)) begin
      e <<= 2;
      k++;
    end
    return int_sqrt(e);
  endfunction

  function automatic logic [15:0] cos_q15(input longint dot, input u64_t ea, input u64_t eb);
    int   ka, kb;
    u64_t ra, rb, d, mag, q, rem;
    ra  = norm_root(ea, ka);
    rb  = norm_root(eb, kb);
    d   = ra * rb;
    mag = (dot < 0) ? u64_t'(-dot) : u64_t'(dot);
    q   = mag / d;
    rem = mag % d;
    if (q > cos_pkg::Q_SAT) q = cos_pkg::Q_SAT;
    for (int i = 0; i < cos_pkg::DIV_BASE_STEPS + ka + kb; i++) begin
      rem <<= 1;
      q <<= 1;
      if (rem >= d) begin
        rem -= d;
        q |= 1;
      end
      if (q > cos_pkg::Q_SAT) q = cos_pkg::Q_SAT;
    end
    if (dot < 0) return (q >= 64'd32768) ? cos_pkg::SIM_MIN : 16'(u64_t'(0) - q);
    return (q >= 64'd32767) ? cos_pkg::SIM_MAX : q[15:0];
  endfunction

  task automatic fold_pair(input logic [15:0] a, input logic [15:0] b, input logic last);
    longint   av, bv, dn;
    u64_t     ea, eb;
    cos_res_t res;
    av = longint'($signed(a));
    bv = longint'($signed(b));
    dn = dot_acc + av * bv;
    ea = energy_a + u64_t'(av * av);
    eb = energy_b + u64_t'(bv * bv);
    dot_acc  = (dn > DOT_HI) ? DOT_HI : ((dn < DOT_LO) ? DOT_LO : dn);
    energy_a = (ea > ENERGY_HI) ? ENERGY_HI : ea;
    energy_b = (eb > ENERGY_HI) ? ENERGY_HI : eb;
    if (last) begin
      res.deg = (energy_a == 0) || (energy_b == 0);
      res.sim = res.deg ? 16'h0000 : cos_q15(dot_acc, energy_a, energy_b);
      cosine_q.push_back(res);
      dot_acc  = 0;
      energy_a = 0;
      energy_b = 0;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  function automatic int rand_gap();
    return $urandom_range(0, 6);
  endfunction

  function automatic logic [15:0] draw_sample();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7fff;
      3: return 16'($urandom_range(0, 6)) - 16'd3;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_pair(input logic [15:0] a, input logic [15:0] b, input logic last,
                            input int gap, input logic drain);
    pair_t p;
    p.a     = a;
    p.b     = b;
    p.last  = last;
    p.gap   = gap;
    p.drain = drain;
    pair_q.push_back(p);
  endtask

  // driver: a pending pair waits out its gap; a drain pair also waits for all results
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      wait_cnt = 0;
    end else if (!in_valid || !in_stall) begin
      if (pair_q.size() != 0 && wait_cnt >= pair_q[0].gap &&
          (!pair_q[0].drain || (!in_valid && cosine_q.size() == 0))) begin
        nxt = pair_q.pop_front();
        in_valid        <= 1'b1;
        in_a_value      <= nxt.a;
        in_b_value      <= nxt.b;
        in_last_element <= nxt.last;
        wait_cnt = 0;
      end else begin
        in_valid <= 1'b0;
        if (pair_q.size() != 0) wait_cnt++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      dot_acc  = 0;
      energy_a = 0;
      energy_b = 0;
    end else if (in_valid && !in_stall) begin
      fold_pair(in_a_value, in_b_value, in_last_element);
    end
  end

  // result side: random hold after each transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      short_stall <= 1'b0;
      hold_left = 0;
    end else if (out_valid && !out_stall) begin
      if (cosine_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result sim=%0d deg=%0b",
                                  $signed(out_similarity), out_degenerate));
      end else begin
        got = cosine_q.pop_front();
        if (out_similarity !== got.sim)
          report_mismatch($sformatf("similarity %0d, expected %0d",
                                    $signed(out_similarity), $signed(got.sim)));
        if (out_degenerate !== got.deg)
          report_mismatch($sformatf("degenerate %0b, expected %0b", out_degenerate, got.deg));
      end
      hold_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
      short_stall <= (hold_left != 0);
    end else if (hold_left != 0) begin
      hold_left--;
      short_stall <= (hold_left != 0);
    end
  end

  // long hold after a chosen transaction, backing up the block
  always @(posedge clk) begin
    if (!rst_n) begin
      long_stall <= 1'b0;
      long_left = 0;
      long_seen = 0;
    end else begin
      if (out_valid && !out_stall) begin
        long_seen++;
        if (long_seen == HOLD_AT) long_left = HOLD_LEN;
      end else if (long_left != 0) begin
        long_left--;
      end
      long_stall <= (long_left != 0);
    end
  end

  initial begin
    int          n_rand;
    int          len;
    int          kind;
    logic        calm;
    logic        drain;
    logic [15:0] a, b;

    queue_pair(16'h7fff, 16'h7fff, 1'b1, rand_gap(), 1'b0);
    queue_pair(16'h8000, 16'h8000, 1'b1, rand_gap(), 1'b0);
    queue_pair(16'h8000, 16'h7fff, 1'b1, rand_gap(), 1'b0);
    queue_pair(16'h7fff, 16'h8000, 1'b1, rand_gap(), 1'b0);
    queue_pair(16'h0000, 16'h0005, 1'b1, rand_gap(), 1'b0);
    queue_pair(16'h0005, 16'h0000, 1'b1, rand_gap(), 1'b0);
    queue_pair(16'h0000, 16'h0000, 1'b1, rand_gap(), 1'b0);
    queue_pair(16'h0001, 16'h0000, 1'b0, rand_gap(), 1'b0);
    queue_pair(16'h0000, 16'h0001, 1'b1, rand_gap(), 1'b0);
    queue_pair(16'h0001, 16'h0001, 1'b1, rand_gap(), 1'b0);
    queue_pair(16'h0001, 16'h8000, 1'b1, rand_gap(), 1'b0);
    queue_pair(16'hffff, 16'hffff, 1'b1, rand_gap(), 1'b0);
    queue_pair(16'h0000, 16'h0007, 1'b0, rand_gap(), 1'b0);
    queue_pair(16'h0000, 16'hfff9, 1'b0, rand_gap(), 1'b0);
    queue_pair(16'h0000, 16'h0001, 1'b1, rand_gap(), 1'b0);
    queue_pair(16'h5555, 16'haaaa, 1'b0, rand_gap(), 1'b1);
    queue_pair(16'haaaa, 16'h5555, 1'b1, rand_gap(), 1'b0);
    queue_pair(16'h0003, 16'h0004, 1'b0, rand_gap(), 1'b0);
    queue_pair(16'h0004, 16'hfffd, 1'b1, rand_gap(), 1'b0);

    // long vectors of extreme samples, positive then negative dot
    for (int i = 0; i < LONG_LEN; i++) begin
      a = (i < LONG_LEN - 8) ? 16'h8000 : draw_sample();
      b = (i < LONG_LEN - 8) ? 16'h8000 : draw_sample();
      queue_pair(a, b, i == LONG_LEN - 1, 0, i == 0);
    end
    for (int i = 0; i < LONG_LEN; i++) begin
      a = (i < LONG_LEN - 8) ? 16'h8000 : draw_sample();
      b = (i < LONG_LEN - 8) ? 16'h7fff : draw_sample();
      queue_pair(a, b, i == LONG_LEN - 1, 0, 1'b0);
    end

    n_rand = 0;
    while (n_rand < 620) begin
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      kind  = $urandom_range(0, 9);
      calm  = ($urandom_range(0, 3) == 0);
      drain = ($urandom_range(0, 24) == 0);
      for (int i = 0; i < len; i++) begin
        a = draw_sample();
        b = draw_sample();
        case (kind)
          0: a = 16'h0000;
          1: b = 16'h0000;
          2: b = a;
          3: b = 16'h0000 - a;
          default: ;
        endcase
        queue_pair(a, b, i == len - 1, calm ? 0 : rand_gap(), drain && i == 0);
      end
      n_rand += len;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    wait (pair_q.size() == 0 && !in_valid);
    wait (cosine_q.size() == 0);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/cos_pkg.sv
hw/rtl/cos_ctrl.sv
hw/rtl/cos_dp.sv
hw/rtl/cosine_similarity.sv
hw/rtl/cos_checker.sv
sim/cosine_similarity_tb.sv
